[design/wbps_pkg.sv]
// Package for the wildcard byte pattern scanner.
// Holds field widths, configuration register indexes and the default chain length.
// No dependencies.
package wbps_pkg;

    // Default and largest number of signature positions (cells in the chain)
    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_PATTERN_LIM = 32;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 64;
    localparam int PAT_REG_W  = 64;
    localparam int PAT_REGS   = 4;
    localparam int PAT_BITS   = PAT_REG_W * PAT_REGS;
    localparam int WILD_W     = 32;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_0 = 3'd0,
        CFG_PATTERN_1 = 3'd1,
        CFG_PATTERN_2 = 3'd2,
        CFG_PATTERN_3 = 3'd3,
        CFG_WILDCARD  = 3'd4,
        CFG_LENGTH    = 3'd5,
        CFG_BASE      = 3'd6
    } t_cfg_reg;

endpackage

[design/wbps_cell.sv]
// One cell of the partial-match chain of the pattern scanner.
// Cell j remembers whether signature positions 0..j matched ending at the prior byte.
// Depends on wbps_pkg.
module wbps_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,     // a byte beat is accepted
    input  logic                        i_clear,    // the accepted beat ends the image
    input  logic [wbps_pkg::BYTE_W-1:0] i_byte,
    input  logic [wbps_pkg::BYTE_W-1:0] i_pat,
    input  logic                        i_wild,
    input  logic                        i_prev,     // match flag from the left neighbor
    output logic                        o_hit,      // positions 0..j match ending at i_byte
    output logic                        o_match     // registered hit, to the right neighbor
);

    logic r_match;
    logic n_match;

    // Extend the neighbor's partial match by this position
    assign o_hit = i_prev & (i_wild | (i_byte == i_pat));

    always_comb begin
        n_match = r_match;
        if (i_step) begin
            n_match = i_clear ? 1'b0 : o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;

endmodule

[design/wildcard_byte_pattern_scan_top.sv]
// Top level of the wildcard byte pattern scanner; depends on wbps_pkg and wbps_cell.
// Usage:
//   Image bytes arrive on the slave stream, one per beat: tdata[7:0] is the
//   byte, tlast marks the final byte of the image. Signature, wildcard mask,
//   length and base address go through the plain write port (index 0..3
//   pattern bytes, 4 wildcard mask, 5 length, 6 base address) while no image
//   is in flight. The master stream carries at most one beat per image: tuser
//   is the found flag and tdata the match address (base plus offset of the
//   first byte of the first matching window), or zero with found low.
// Timing:
//   One byte per cycle sustained while tready stays high. A row of MAX_PATTERN
//   cells advances a partial-match flag per signature position on each byte,
//   so the compare keeps pace with the bytes whatever the length. A result
//   beat reaches the master stream through one pending register, then the
//   output register where the address add is done.
// Reset and stall:
//   Reset clears the chain, byte count and both result registers and loads
//   the register reset values (length 1). A stalled output lets the pending
//   register absorb one more result; tready drops only when both are full
//   and the output beat is not taken.
module wildcard_byte_pattern_scan_top #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Byte stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,    // [7:0] data_byte
    input  logic                            i_s_tlast,    // last_byte
    // Result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wbps_pkg::ADDR_W-1:0]     o_m_tdata,    // [63:0] match_address
    output logic                            o_m_tuser,    // [0] found
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int BW = wbps_pkg::BYTE_W;
    localparam int AW = wbps_pkg::ADDR_W;
    localparam int LW = wbps_pkg::LEN_W;
    localparam int PW = wbps_pkg::PAT_REG_W;

    // Configuration registers
    logic [wbps_pkg::PAT_BITS-1:0] r_pattern;
    logic [wbps_pkg::WILD_W-1:0]   r_wild;
    logic [LW-1:0]                 r_length;
    logic [AW-1:0]                 r_base;

    // Scan state
    logic [AW-1:0]                 r_seen;
    logic [AW-1:0]                 n_seen;
    logic                          r_reported;
    logic                          n_reported;

    // Result registers: pending stage and output stage
    logic                          r_p_valid;
    logic                          r_p_found;
    logic [AW-1:0]                 r_p_seen;
    logic                          r_o_valid;
    logic                          r_o_found;
    logic [AW-1:0]                 r_o_addr;

    logic                          step;
    logic                          p_move;
    logic [LW-1:0]                 len_c;
    logic [MAX_PATTERN-1:0]        hit;
    logic [MAX_PATTERN-1:0]        chain;
    logic                          full_hit;
    logic                          new_match;
    logic                          produce;
    logic [AW-1:0]                 addr_calc;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_wild    <= '0;
            r_length  <= LW'(1);
            r_base    <= '0;
        end else if (i_cfg_we) begin
            unique case (wbps_pkg::t_cfg_reg'(i_cfg_index))
                wbps_pkg::CFG_PATTERN_0: r_pattern[0*PW +: PW] <= i_cfg_wdata;
                wbps_pkg::CFG_PATTERN_1: r_pattern[1*PW +: PW] <= i_cfg_wdata;
                wbps_pkg::CFG_PATTERN_2: r_pattern[2*PW +: PW] <= i_cfg_wdata;
                wbps_pkg::CFG_PATTERN_3: r_pattern[3*PW +: PW] <= i_cfg_wdata;
                wbps_pkg::CFG_WILDCARD:  r_wild   <= i_cfg_wdata[wbps_pkg::WILD_W-1:0];
                wbps_pkg::CFG_LENGTH:    r_length <= i_cfg_wdata[LW-1:0];
                wbps_pkg::CFG_BASE:      r_base   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: pending stage drains into the output stage
    assign p_move     = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_p_valid || p_move;
    assign step       = i_s_tvalid && o_s_tready;

    // Lengths past the chain size use the whole chain
    assign len_c = (r_length > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : r_length;

    // Partial-match chain, position 0 always has an empty prefix matched
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (step),
            .i_clear (i_s_tlast),
            .i_byte  (i_s_tdata),
            .i_pat   (r_pattern[BW*j +: BW]),
            .i_wild  (r_wild[j]),
            .i_prev  ((j == 0) ? 1'b1 : chain[(j == 0) ? 0 : j-1]),
            .o_hit   (hit[j]),
            .o_match (chain[j])
        );
    end

    // Pick the hit of the last signature position; length zero never hits
    always_comb begin
        full_hit = 1'b0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            full_hit = full_hit | (hit[j] & (len_c == LW'(j + 1)));
        end
    end

    assign new_match = !r_reported && full_hit;
    assign produce   = new_match || (i_s_tlast && !r_reported);

    // Byte count (saturating) and report flag
    always_comb begin
        n_seen     = r_seen;
        n_reported = r_reported;
        if (step) begin
            n_seen     = i_s_tlast ? '0 : ((&r_seen) ? r_seen : r_seen + AW'(1));
            n_reported = i_s_tlast ? 1'b0 : (r_reported | full_hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_reported <= n_reported;
        end
    end

    // Pending result stage: holds the count including the matching byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_p_valid <= step && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && produce) begin
            r_p_found <= new_match;
            r_p_seen  <= (&r_seen) ? r_seen : r_seen + AW'(1);
        end
    end

    // Output stage: start offset is count minus length, plus base
    assign addr_calc = r_p_found ? (r_base + r_p_seen - AW'(len_c)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move && r_p_valid) begin
            r_o_found <= r_p_found;
            r_o_addr  <= addr_calc;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_addr;
    assign o_m_tuser  = r_o_found;

endmodule

[design/wbps_checker.sv]
// Port-level checker for the wildcard byte pattern scanner, bound to the top level.
// Depends on wbps_pkg and wildcard_byte_pattern_scan_top.
module wbps_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_s_tready,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [wbps_pkg::ADDR_W-1:0]     o_m_tdata,
    input  logic                            o_m_tuser
);

    // A stalled result beat holds its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // A not-found beat carries a zero address
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("not-found result with nonzero address");

    // Input backpressure only while the output is full and stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output backpressure");

    // Reset empties the result path
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind wildcard_byte_pattern_scan_top wbps_checker u_wbps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
